@@ rtl/pida_pkg.sv @@
package pida_pkg;

    // Field widths fixed by the identifier format.
    localparam int PID_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;
    localparam int ERR_W    = 2;
    localparam int NEXT_W   = 9;
    localparam int ID_SPACE = 256;

    // Command codes carried in a request beat.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_CHANGE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Error codes returned in a response beat.
    localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNASSIGNED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EXHAUSTED  = 2'd2;

    // Lifetime status codes.
    localparam logic [STATUS_W-1:0] STATUS_FREE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW  = 2'd3;

    // Register map: one register, selected by word address bit.
    localparam logic REG_FIRST_PID   = 1'b0;
    localparam logic [PID_W-1:0] FIRST_PID_RESET = 8'd2;

    // Enables for one synchronous memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

@@ rtl/pida_if.sv @@
// Request channel: one command beat.
interface pida_req_if
    import pida_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PID_W-1:0]  pid;
    logic [STATUS_W-1:0] status_mask;

    modport source (output valid, output command, output pid, output status_mask,
                    input ready);
    modport sink   (input valid, input command, input pid, input status_mask,
                    output ready);
endinterface

// Response channel: one result beat.
interface pida_rsp_if
    import pida_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PID_W-1:0] granted_pid;
    logic             in_use;
    logic [ERR_W-1:0] error_code;

    modport source (output valid, output granted_pid, output in_use, output error_code,
                    input ready);
    modport sink   (input valid, input granted_pid, input in_use, input error_code,
                    output ready);
endinterface

@@ rtl/pida_status_mem.sv @@
module pida_status_mem
    import pida_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mem_ctl_t            ctl,
    input  logic [AW-1:0]       rd_addr,
    output logic [STATUS_W-1:0] rd_data,
    input  logic [AW-1:0]       wr_addr,
    input  logic [STATUS_W-1:0] wr_data
);

    logic [STATUS_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [STATUS_W-1:0] data_reg;
    logic                hit_reg;

    // Valid bits stand in for clearing the table at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Storage with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    // An entry never written reads as free.
    assign rd_data = hit_reg ? data_reg : STATUS_FREE;

endmodule

@@ rtl/pida_free_stack.sv @@
module pida_free_stack
    import pida_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  mem_ctl_t         ctl,
    input  logic [AW-1:0]    rd_addr,
    output logic [PID_W-1:0] rd_data,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PID_W-1:0] wr_data
);

    logic [PID_W-1:0] mem [DEPTH];
    logic [PID_W-1:0] data_reg;

    // Stack storage; the pointer lives in the controller.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

@@ rtl/pid_allocator_with_exit_status.sv @@
// Channel   Direction  Beat contents
// req       in         command, pid, status_mask
// rsp       out        granted_pid, in_use, error_code
// apb       in/out     first_pid register at byte address 0
//
// On acceptance a request reads the status table and the top of the free
// stack; in the S_EXEC state the block then modifies and writes them back
// and loads the response register. A new request is taken while a response
// waits. Reset clears the status table through per-entry valid bits, so no
// clearing pass is needed. A stalled response holds the block in S_EXEC
// until the beat is taken.
module pid_allocator_with_exit_status
    import pida_pkg::*;
#(
    parameter int MAX_PIDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pida_req_if.sink    req,
    pida_rsp_if.source  rsp
);

    localparam int TBL_DEPTH = (MAX_PIDS < ID_SPACE) ? MAX_PIDS : ID_SPACE;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int STK_AW    = $clog2(MAX_PIDS);
    localparam int FCW       = $clog2(MAX_PIDS + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [PID_W-1:0]    pid_reg, pid_next;
    logic [STATUS_W-1:0] mask_reg, mask_next;
    logic [FCW-1:0]      free_count_reg, free_count_next;
    logic [NEXT_W-1:0]   next_fresh_reg, next_fresh_next;
    logic [PID_W-1:0]    first_pid_reg, first_pid_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [PID_W-1:0]    granted_reg, granted_next;
    logic                in_use_reg, in_use_next;
    logic [ERR_W-1:0]    error_reg, error_next;

    mem_ctl_t            tbl_ctl, stk_ctl;
    logic [TBL_AW-1:0]   tbl_wr_addr;
    logic [STATUS_W-1:0] tbl_rd_data, tbl_wr_data;
    logic [STK_AW-1:0]   stk_rd_addr, stk_wr_addr;
    logic [PID_W-1:0]    stk_rd_data, stk_wr_data;
    logic [FCW-1:0]      pop_index;
    logic [STATUS_W-1:0] masked_status;
    logic                cfg_wr, exec_fire, pid_ok, stack_room;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FIRST_PID);
    assign prdata = (paddr[2] == REG_FIRST_PID) ? {24'd0, first_pid_reg} : 32'd0;

    // Stack pointer arithmetic and range checks.
    assign pop_index     = free_count_reg - FCW'(1);
    assign stk_rd_addr   = pop_index[STK_AW-1:0];
    assign stk_wr_addr   = free_count_reg[STK_AW-1:0];
    assign stk_wr_data   = pid_reg;
    assign stack_room    = 32'(free_count_reg) < MAX_PIDS;
    assign pid_ok        = 32'(pid_reg) < MAX_PIDS;
    assign masked_status = tbl_rd_data & mask_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign exec_fire = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Sequencer: read on acceptance, modify and write back in S_EXEC once the response register is free.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pid_next        = pid_reg;
        mask_next       = mask_reg;
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        first_pid_next  = first_pid_reg;
        rsp_valid_next  = rsp_valid_reg;
        granted_next    = granted_reg;
        in_use_next     = in_use_reg;
        error_next      = error_reg;
        tbl_ctl         = '0;
        stk_ctl         = '0;
        tbl_wr_addr     = pid_reg[TBL_AW-1:0];
        tbl_wr_data     = masked_status;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            first_pid_next  = pwdata[PID_W-1:0];
            next_fresh_next = {1'b0, pwdata[PID_W-1:0]};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = cmd_t'(req.command);
                    pid_next      = req.pid;
                    mask_next     = req.status_mask;
                    tbl_ctl.rd_en = 1'b1;
                    stk_ctl.rd_en = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    granted_next   = '0;
                    in_use_next    = 1'b0;
                    error_next     = ERR_OK;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            // Reuse the most recently freed identifier first.
                            if (free_count_reg != '0)
                            begin
                                granted_next    = stk_rd_data;
                                free_count_next = pop_index;
                            end
                            else if (32'(next_fresh_reg) < TBL_DEPTH)
                            begin
                                granted_next    = next_fresh_reg[PID_W-1:0];
                                next_fresh_next = next_fresh_reg + NEXT_W'(1);
                            end
                            else
                            begin
                                error_next = ERR_EXHAUSTED;
                            end
                            if (error_next == ERR_OK && 32'(granted_next) < MAX_PIDS)
                            begin
                                tbl_ctl.wr_en = 1'b1;
                                tbl_wr_addr   = granted_next[TBL_AW-1:0];
                                tbl_wr_data   = STATUS_NEW;
                            end
                        end
                        CMD_CHANGE:
                        begin
                            if (!pid_ok || tbl_rd_data == STATUS_FREE)
                            begin
                                error_next = ERR_UNASSIGNED;
                            end
                            else
                            begin
                                tbl_ctl.wr_en = 1'b1;
                                // A status that drops to free goes on the stack when there is room.
                                if (masked_status == STATUS_FREE && stack_room)
                                begin
                                    stk_ctl.wr_en   = 1'b1;
                                    free_count_next = free_count_reg + FCW'(1);
                                end
                            end
                        end
                        CMD_QUERY:
                        begin
                            in_use_next = pid_ok && (tbl_rd_data != STATUS_FREE);
                        end
                        default:
                        begin
                            error_next = ERR_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the registered response beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            next_fresh_reg <= {1'b0, FIRST_PID_RESET};
            first_pid_reg  <= FIRST_PID_RESET;
            rsp_valid_reg  <= 1'b0;
            granted_reg    <= '0;
            in_use_reg     <= 1'b0;
            error_reg      <= ERR_OK;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            next_fresh_reg <= next_fresh_next;
            first_pid_reg  <= first_pid_next;
            rsp_valid_reg  <= rsp_valid_next;
            granted_reg    <= granted_next;
            in_use_reg     <= in_use_next;
            error_reg      <= error_next;
        end
    end

    // Captured request.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pid_reg  <= pid_next;
        mask_reg <= mask_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.granted_pid = granted_reg;
    assign rsp.in_use      = in_use_reg;
    assign rsp.error_code  = error_reg;

    pida_status_mem #(
        .DEPTH (TBL_DEPTH),
        .AW    (TBL_AW)
    ) u_status (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .rd_addr (req.pid[TBL_AW-1:0]),
        .rd_data (tbl_rd_data),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    pida_free_stack #(
        .DEPTH (MAX_PIDS),
        .AW    (STK_AW)
    ) u_stack (
        .clk     (clk),
        .ctl     (stk_ctl),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data)
    );

endmodule
